### src/cbm_pkg.sv
package cbm_pkg;

    localparam int ADDR_W          = 16;
    localparam int DATA_W          = 8;
    localparam int BANK_W          = 8;
    localparam int PAGE_OFFSET_W   = 14;
    localparam int OFFSET_W        = 22;
    localparam int ROM_OFFSET_BITS = 22;
    localparam int COUNT_W         = 9;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 9;
    localparam int DIV_STEPS       = 8;
    localparam int DIV_CNT_W       = 3;

    localparam logic [OFFSET_W-1:0] ROM_OFFSET_MASK =
        OFFSET_W'((64'd1 << ROM_OFFSET_BITS) - 64'd1);

    localparam logic [ADDR_W-1:0] ADDR_SYS_REG   = 16'hFFFC;
    localparam logic [ADDR_W-1:0] ADDR_REG_8000  = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_REG_A000  = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_BOOT_END  = 16'h0400;
    localparam logic [ADDR_W-1:0] ADDR_WRAM_MASK = 16'h1FFF;

    localparam int CTL_RAM_EN_BIT   = 3;
    localparam int CTL_RAM_HALF_BIT = 2;

    localparam logic [COUNT_W-1:0] BANK_COUNT_MIN   = 9'd4;
    localparam logic [COUNT_W-1:0] BANK_COUNT_MAX   = 9'd256;
    localparam logic [COUNT_W-1:0] BANK_COUNT_RESET = 9'd32;

    localparam logic [BANK_W-1:0] PAGE0_RESET = 8'd0;
    localparam logic [BANK_W-1:0] PAGE1_RESET = 8'd1;
    localparam logic [BANK_W-1:0] PAGE2_RESET = 8'd2;
    localparam logic [BANK_W-1:0] CTL3_RESET  = 8'd2;

    localparam logic [1:0] PAGE_0 = 2'd0;
    localparam logic [1:0] PAGE_1 = 2'd1;
    localparam logic [1:0] PAGE_2 = 2'd2;
    localparam logic [1:0] PAGE_3 = 2'd3;

    // Paging registers at the top of the address space.
    localparam logic [1:0] SYS_REG_RAM   = 2'd0;
    localparam logic [1:0] SYS_REG_PAGE0 = 2'd1;
    localparam logic [1:0] SYS_REG_PAGE1 = 2'd2;
    localparam logic [1:0] SYS_REG_PAGE2 = 2'd3;

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_WRAM = 2'd1,
        TGT_CRAM = 2'd2,
        TGT_NONE = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        MODE_STD      = 2'd0,
        MODE_REG_8000 = 2'd1,
        MODE_REG_A000 = 2'd2,
        MODE_STD_ALT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAPPER_MODE = 1'b0,
        CFG_BANK_COUNT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DST_P0,
        DST_P1,
        DST_P2
    } t_dest;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_sts;

    function automatic logic [OFFSET_W-1:0] rom_offset(
        input logic [BANK_W-1:0] bank,
        input logic [ADDR_W-1:0] addr
    );
        logic [OFFSET_W-1:0] full;
        full = OFFSET_W'({bank, addr[PAGE_OFFSET_W-1:0]});
        return full & ROM_OFFSET_MASK;
    endfunction

endpackage

### src/cbm_in_if.sv
interface cbm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [cbm_pkg::ADDR_W-1:0]    address;
    logic [cbm_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, action, address, write_data, input ready);
    modport sink   (input valid, action, address, write_data, output ready);
endinterface

### src/cbm_out_if.sv
interface cbm_out_if;
    logic                          valid;
    logic                          ready;
    cbm_pkg::t_target              target;
    logic [cbm_pkg::OFFSET_W-1:0]  memory_offset;
    logic                          write_strobe;
    logic                          battery_ram_used;

    modport source (output valid, target, memory_offset, write_strobe, battery_ram_used,
                    input ready);
    modport sink   (input valid, target, memory_offset, write_strobe, battery_ram_used,
                    output ready);
endinterface

### src/cbm_ctrl.sv
module cbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cbm_pkg::t_sts i_sts,
    output cbm_pkg::t_cmd o_cmd
);

    localparam logic [cbm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        cbm_pkg::DIV_CNT_W'(cbm_pkg::DIV_STEPS - 1);

    cbm_pkg::t_state                r_state;
    cbm_pkg::t_state                n_state;
    logic [cbm_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [cbm_pkg::DIV_CNT_W-1:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbm_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            cbm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.need_div ? cbm_pkg::ST_DIVIDE : cbm_pkg::ST_EMIT;
                end
            end
            cbm_pkg::ST_DIVIDE: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = cbm_pkg::ST_EMIT;
                    n_cnt   = '0;
                end
            end
            cbm_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = cbm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == cbm_pkg::ST_IDLE);
        o_cmd.load     = (r_state == cbm_pkg::ST_IDLE) && i_in_valid;
        o_cmd.div_step = (r_state == cbm_pkg::ST_DIVIDE);
        o_cmd.div_last = (r_state == cbm_pkg::ST_DIVIDE) && (r_cnt == DIV_LAST);
        o_cmd.emit     = (r_state == cbm_pkg::ST_EMIT) && i_sts.out_free;
    end

    // A pending result is never dropped while the output register is full.
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbm_pkg::ST_EMIT) && !i_sts.out_free |=> (r_state == cbm_pkg::ST_EMIT))
        else $error("pending result left before it was moved to the output");

    // A paging write starts the modulo sequence from its first step.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load && i_sts.need_div |=> (r_state == cbm_pkg::ST_DIVIDE) && (r_cnt == '0))
        else $error("modulo sequence did not start cleanly");

    // The modulo sequence ends after its last step, never earlier.
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbm_pkg::ST_DIVIDE) && (r_cnt != DIV_LAST) |=>
            (r_state == cbm_pkg::ST_DIVIDE))
        else $error("modulo sequence ended early");

endmodule

### src/cbm_datapath.sv
module cbm_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cbm_pkg::t_cmd                    i_cmd,
    output cbm_pkg::t_sts                    o_sts,
    input  logic                             i_action,
    input  logic [cbm_pkg::ADDR_W-1:0]       i_address,
    input  logic [cbm_pkg::DATA_W-1:0]       i_write_data,
    input  logic                             i_cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output cbm_pkg::t_target                 o_target,
    output logic [cbm_pkg::OFFSET_W-1:0]     o_memory_offset,
    output logic                             o_write_strobe,
    output logic                             o_battery_ram_used
);

    // Configuration and paging state.
    cbm_pkg::t_mode                  r_mode;
    logic [cbm_pkg::COUNT_W-1:0]     r_bank_count;
    logic [cbm_pkg::BANK_W-1:0]      r_page0_bank;
    logic [cbm_pkg::BANK_W-1:0]      r_page1_bank;
    logic [cbm_pkg::BANK_W-1:0]      r_page2_bank;
    logic [cbm_pkg::DATA_W-1:0]      r_ctl3;
    logic                            r_ctl0_ram;
    logic                            r_p2_ram;
    logic                            r_ram_upper;
    logic                            r_ram_ever;

    // Bit-serial modulo unit.
    logic [cbm_pkg::DATA_W-1:0]      r_div_num;
    logic [cbm_pkg::BANK_W-1:0]      r_rem;
    cbm_pkg::t_dest                  r_div_dst;

    // Pending result and output register.
    cbm_pkg::t_target                r_pend_target;
    logic [cbm_pkg::OFFSET_W-1:0]    r_pend_offset;
    logic                            r_pend_strobe;
    logic                            r_pend_battery;
    logic                            r_out_valid;
    cbm_pkg::t_target                r_out_target;
    logic [cbm_pkg::OFFSET_W-1:0]    r_out_offset;
    logic                            r_out_strobe;
    logic                            r_out_battery;

    logic [1:0]                      page;
    logic                            std_mode;
    logic                            reg_write;
    logic                            std_write;
    logic [1:0]                      std_sel;
    logic                            ram_map_write;
    logic [cbm_pkg::OFFSET_W-1:0]    cram_offset;
    logic [cbm_pkg::OFFSET_W-1:0]    wram_offset;
    cbm_pkg::t_target                eval_target;
    logic [cbm_pkg::OFFSET_W-1:0]    eval_offset;
    logic                            eval_strobe;
    logic                            need_div;
    cbm_pkg::t_dest                  div_dst;
    logic [cbm_pkg::DATA_W-1:0]      div_val;
    logic [cbm_pkg::COUNT_W-1:0]     div_n;
    logic [cbm_pkg::COUNT_W-1:0]     rem_sh;
    logic [cbm_pkg::COUNT_W-1:0]     rem_nx;

    assign page      = i_address[cbm_pkg::ADDR_W-1 -: 2];
    assign std_mode  = (r_mode == cbm_pkg::MODE_STD) || (r_mode == cbm_pkg::MODE_STD_ALT);
    assign reg_write = i_action &&
        (((r_mode == cbm_pkg::MODE_REG_8000) && (i_address == cbm_pkg::ADDR_REG_8000)) ||
         ((r_mode == cbm_pkg::MODE_REG_A000) && (i_address == cbm_pkg::ADDR_REG_A000)));
    assign std_write = i_action && !reg_write && std_mode &&
                       (i_address >= cbm_pkg::ADDR_SYS_REG);
    assign std_sel   = i_address[1:0];
    assign ram_map_write = std_write && (std_sel == cbm_pkg::SYS_REG_RAM) &&
                           i_write_data[cbm_pkg::CTL_RAM_EN_BIT];

    assign cram_offset = cbm_pkg::OFFSET_W'({r_ram_upper,
                                             i_address[cbm_pkg::PAGE_OFFSET_W-1:0]});
    assign wram_offset = cbm_pkg::OFFSET_W'(i_address & cbm_pkg::ADDR_WRAM_MASK);

    // Translation uses the paging state as it stood before this beat.
    always_comb begin
        eval_target = cbm_pkg::TGT_NONE;
        eval_offset = '0;
        eval_strobe = 1'b0;
        if (!i_action) begin
            if (i_address < cbm_pkg::ADDR_BOOT_END) begin
                eval_target = cbm_pkg::TGT_ROM;
                eval_offset = cbm_pkg::rom_offset('0, i_address);
            end else begin
                unique case (page)
                    cbm_pkg::PAGE_0: begin
                        eval_target = cbm_pkg::TGT_ROM;
                        eval_offset = cbm_pkg::rom_offset(r_page0_bank, i_address);
                    end
                    cbm_pkg::PAGE_1: begin
                        eval_target = cbm_pkg::TGT_ROM;
                        eval_offset = cbm_pkg::rom_offset(r_page1_bank, i_address);
                    end
                    cbm_pkg::PAGE_2: begin
                        if (r_p2_ram) begin
                            eval_target = cbm_pkg::TGT_CRAM;
                            eval_offset = cram_offset;
                        end else begin
                            eval_target = cbm_pkg::TGT_ROM;
                            eval_offset = cbm_pkg::rom_offset(r_page2_bank, i_address);
                        end
                    end
                    default: begin
                        eval_target = cbm_pkg::TGT_WRAM;
                        eval_offset = wram_offset;
                    end
                endcase
            end
        end else if (!reg_write) begin
            if (page == cbm_pkg::PAGE_3) begin
                eval_target = cbm_pkg::TGT_WRAM;
                eval_offset = wram_offset;
                eval_strobe = 1'b1;
            end else if ((page == cbm_pkg::PAGE_2) && r_p2_ram) begin
                eval_target = cbm_pkg::TGT_CRAM;
                eval_offset = cram_offset;
                eval_strobe = 1'b1;
            end
        end
    end

    // Which bank register a write reloads, and from which byte.
    always_comb begin
        need_div = 1'b0;
        div_dst  = cbm_pkg::DST_P2;
        div_val  = i_write_data;
        if (reg_write) begin
            need_div = 1'b1;
        end else if (std_write) begin
            unique case (std_sel)
                cbm_pkg::SYS_REG_RAM: begin
                    need_div = !i_write_data[cbm_pkg::CTL_RAM_EN_BIT];
                    div_val  = r_ctl3;
                end
                cbm_pkg::SYS_REG_PAGE0: begin
                    need_div = 1'b1;
                    div_dst  = cbm_pkg::DST_P0;
                end
                cbm_pkg::SYS_REG_PAGE1: begin
                    need_div = 1'b1;
                    div_dst  = cbm_pkg::DST_P1;
                end
                default: begin
                    need_div = !r_ctl0_ram;
                end
            endcase
        end
    end

    // One quotient bit per step; the divisor is the clamped bank count.
    always_comb begin
        if (r_bank_count < cbm_pkg::BANK_COUNT_MIN) begin
            div_n = cbm_pkg::BANK_COUNT_MIN;
        end else if (r_bank_count > cbm_pkg::BANK_COUNT_MAX) begin
            div_n = cbm_pkg::BANK_COUNT_MAX;
        end else begin
            div_n = r_bank_count;
        end
        rem_sh = {r_rem, r_div_num[cbm_pkg::DATA_W-1]};
        rem_nx = (rem_sh >= div_n) ? (rem_sh - div_n) : rem_sh;
    end

    assign o_sts.need_div = need_div;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= cbm_pkg::MODE_STD;
            r_bank_count <= cbm_pkg::BANK_COUNT_RESET;
            r_page0_bank <= cbm_pkg::PAGE0_RESET;
            r_page1_bank <= cbm_pkg::PAGE1_RESET;
            r_page2_bank <= cbm_pkg::PAGE2_RESET;
            r_ctl3       <= cbm_pkg::CTL3_RESET;
            r_ctl0_ram   <= 1'b0;
            r_p2_ram     <= 1'b0;
            r_ram_upper  <= 1'b0;
            r_ram_ever   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (cbm_pkg::t_cfg_idx'(i_cfg_idx))
                    cbm_pkg::CFG_MAPPER_MODE: begin
                        r_mode <= cbm_pkg::t_mode'(i_cfg_data[cbm_pkg::MODE_W-1:0]);
                    end
                    default: begin
                        r_bank_count <= i_cfg_data;
                    end
                endcase
            end
            if (i_cmd.load) begin
                if (reg_write) begin
                    r_ctl0_ram <= i_write_data[cbm_pkg::CTL_RAM_EN_BIT];
                    r_p2_ram   <= 1'b0;
                end else if (std_write) begin
                    if (std_sel == cbm_pkg::SYS_REG_RAM) begin
                        r_ctl0_ram <= i_write_data[cbm_pkg::CTL_RAM_EN_BIT];
                        r_p2_ram   <= i_write_data[cbm_pkg::CTL_RAM_EN_BIT];
                        if (i_write_data[cbm_pkg::CTL_RAM_EN_BIT]) begin
                            r_ram_upper <= i_write_data[cbm_pkg::CTL_RAM_HALF_BIT];
                            r_ram_ever  <= 1'b1;
                        end
                    end else if (std_sel == cbm_pkg::SYS_REG_PAGE2) begin
                        r_ctl3 <= i_write_data;
                    end
                end
            end
            if (i_cmd.div_last) begin
                unique case (r_div_dst)
                    cbm_pkg::DST_P0: r_page0_bank <= rem_nx[cbm_pkg::BANK_W-1:0];
                    cbm_pkg::DST_P1: r_page1_bank <= rem_nx[cbm_pkg::BANK_W-1:0];
                    default:         r_page2_bank <= rem_nx[cbm_pkg::BANK_W-1:0];
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pend_target  <= eval_target;
            r_pend_offset  <= eval_offset;
            r_pend_strobe  <= eval_strobe;
            r_pend_battery <= r_ram_ever || ram_map_write;
            r_div_num      <= div_val;
            r_div_dst      <= div_dst;
            r_rem          <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_nx[cbm_pkg::BANK_W-1:0];
            r_div_num <= {r_div_num[cbm_pkg::DATA_W-2:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_out_target  <= r_pend_target;
            r_out_offset  <= r_pend_offset;
            r_out_strobe  <= r_pend_strobe;
            r_out_battery <= r_pend_battery;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_target           = r_out_target;
    assign o_memory_offset    = r_out_offset;
    assign o_write_strobe     = r_out_strobe;
    assign o_battery_ram_used = r_out_battery;

    // A result only moves into the output register when it is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while full");

    // The partial remainder stays below the divisor after every step.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> ({1'b0, r_rem} < $past(div_n)))
        else $error("modulo remainder out of range");

endmodule

### src/console_bank_mapper.sv
// Console bank mapper: translates 8-bit CPU accesses in a 64 KiB space into a
// target memory (cartridge ROM, work RAM, cartridge RAM, or a discarded write)
// and a byte offset in it, and applies paging writes to its bank registers.
// Request beats arrive on i_req (action, address, write_data); each produces
// exactly one response beat on o_rsp (target, memory_offset, write_strobe,
// battery_ram_used). Both channels move a beat when valid and ready are high.
// The mapper works on one beat at a time. A read or a write that does not
// reload a bank register moves from the pending register into the output
// register once that is free, and the next request is taken after that move.
// A write that reloads a bank holds the mapper in the divide state first,
// because the bank number is reduced modulo the bank count by a bit-serial
// divider that retires one quotient bit per cycle; its response then follows.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits; a stalled receiver holds at most one
// response there and one pending behind it before i_req.ready drops.
// Synchronous active-low reset restores mode 0, 32 banks, pages 0/1/2 on
// banks 0/1/2 and cartridge RAM unmapped; there is no clearing pass. The user
// writes configuration (index 0 mapper mode, index 1 bank count) through
// i_cfg_we/i_cfg_idx/i_cfg_data only while no beat is in flight (not enforced).
module console_bank_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbm_in_if.sink                          i_req,
    cbm_out_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cbm_pkg::t_cmd cmd;
    cbm_pkg::t_sts sts;
    logic          in_ready;

    // The sequencer decides when a beat is taken, when the divider steps and
    // when the finished result moves to the output register.
    cbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the paging state, translates the address, runs the
    // modulo unit and owns the output register.
    cbm_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_action           (i_req.action),
        .i_address          (i_req.address),
        .i_write_data       (i_req.write_data),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_target           (o_rsp.target),
        .o_memory_offset    (o_rsp.memory_offset),
        .o_write_strobe     (o_rsp.write_strobe),
        .o_battery_ram_used (o_rsp.battery_ram_used)
    );

    assign i_req.ready = in_ready;

endmodule
